/* design/aabb_pkg.sv */
// Shared types, widths, register indexes and reset values for the box transform.
// Used by the transform top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package aabb_pkg;

   localparam int COORD_W  = 32;
   localparam int CSR_W    = 64;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_AXES = 3;
   localparam int PROD_W   = 2 * COORD_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int ACC_W    = SUM_W + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic [CSR_W-1:0]          csr_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;

   localparam csr_idx_type CSR_ROW_X_LIN = 3'd0;
   localparam csr_idx_type CSR_ROW_X_AFF = 3'd1;
   localparam csr_idx_type CSR_ROW_Y_LIN = 3'd2;
   localparam csr_idx_type CSR_ROW_Y_AFF = 3'd3;
   localparam csr_idx_type CSR_ROW_Z_LIN = 3'd4;
   localparam csr_idx_type CSR_ROW_Z_AFF = 3'd5;

   localparam csr_type RST_ROW_X_LIN = 64'h0000_0001_0000_0000;
   localparam csr_type RST_ROW_X_AFF = 64'h0000_0000_0000_0000;
   localparam csr_type RST_ROW_Y_LIN = 64'h0000_0000_0001_0000;
   localparam csr_type RST_ROW_Y_AFF = 64'h0000_0000_0000_0000;
   localparam csr_type RST_ROW_Z_LIN = 64'h0000_0000_0000_0000;
   localparam csr_type RST_ROW_Z_AFF = 64'h0001_0000_0000_0000;

   localparam acc_type ACC_COORD_MAX = acc_type'(64'sh0000_0000_7FFF_FFFF);
   localparam acc_type ACC_COORD_MIN = -acc_type'(64'sh0000_0000_8000_0000);

   function automatic coord_type saturate(input acc_type v);
      coord_type r;
      if (v > ACC_COORD_MAX) begin
         r = coord_type'(32'sh7FFF_FFFF);
      end else if (v < ACC_COORD_MIN) begin
         r = coord_type'(32'sh8000_0000);
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

/* design/aabb_affine_transform.sv */
// Top level of the axis-aligned box transform: configuration registers and datapath.
// Depends on aabb_pkg for widths, register indexes, reset values and saturation.
`timescale 1ns / 1ps

// One box is accepted in every cycle and busy never rises. Each result appears on the
// rsp_ ports for exactly one cycle with rsp_valid, once its box has passed the five
// register stages; the receiver cannot stall and must take it then. The stages are:
// the eighteen matrix-by-coordinate products, the choice of the smaller and larger
// product for each matrix entry, the sum of three products per row, the fraction
// shift with the translation, and saturation. Matrix writes must be made only while
// no box is in flight; the block itself does not enforce this.
module aabb_affine_transform #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               busy,
   input  aabb_pkg::coord_type req_box_min_x,
   input  aabb_pkg::coord_type req_box_min_y,
   input  aabb_pkg::coord_type req_box_min_z,
   input  aabb_pkg::coord_type req_box_max_x,
   input  aabb_pkg::coord_type req_box_max_y,
   input  aabb_pkg::coord_type req_box_max_z,
   output logic               rsp_valid,
   output aabb_pkg::coord_type rsp_out_min_x,
   output aabb_pkg::coord_type rsp_out_min_y,
   output aabb_pkg::coord_type rsp_out_min_z,
   output aabb_pkg::coord_type rsp_out_max_x,
   output aabb_pkg::coord_type rsp_out_max_y,
   output aabb_pkg::coord_type rsp_out_max_z,
   input  logic               csr_we,
   input  aabb_pkg::csr_idx_type csr_index,
   input  aabb_pkg::csr_type  csr_wdata
);
   import aabb_pkg::*;

   csr_type   lin_ff [NUM_AXES];
   csr_type   aff_ff [NUM_AXES];
   csr_type   lin_in [NUM_AXES];
   csr_type   aff_in [NUM_AXES];

   coord_type mat    [NUM_AXES][NUM_AXES];
   coord_type trans  [NUM_AXES];
   coord_type box_lo [NUM_AXES];
   coord_type box_hi [NUM_AXES];

   logic      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   prod_type  plo_ff [NUM_AXES][NUM_AXES];
   prod_type  phi_ff [NUM_AXES][NUM_AXES];
   prod_type  plo_in [NUM_AXES][NUM_AXES];
   prod_type  phi_in [NUM_AXES][NUM_AXES];
   prod_type  tmin_ff [NUM_AXES][NUM_AXES];
   prod_type  tmax_ff [NUM_AXES][NUM_AXES];
   prod_type  tmin_in [NUM_AXES][NUM_AXES];
   prod_type  tmax_in [NUM_AXES][NUM_AXES];
   sum_type   smin_ff [NUM_AXES];
   sum_type   smax_ff [NUM_AXES];
   sum_type   smin_in [NUM_AXES];
   sum_type   smax_in [NUM_AXES];
   acc_type   amin_ff [NUM_AXES];
   acc_type   amax_ff [NUM_AXES];
   acc_type   amin_in [NUM_AXES];
   acc_type   amax_in [NUM_AXES];
   coord_type omin_ff [NUM_AXES];
   coord_type omax_ff [NUM_AXES];
   coord_type omin_in [NUM_AXES];
   coord_type omax_in [NUM_AXES];

   logic      accept;

   assign busy   = 1'b0;
   assign accept = req_start && !busy;

   assign box_lo[0] = req_box_min_x;
   assign box_lo[1] = req_box_min_y;
   assign box_lo[2] = req_box_min_z;
   assign box_hi[0] = req_box_max_x;
   assign box_hi[1] = req_box_max_y;
   assign box_hi[2] = req_box_max_z;

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         mat[r][0] = lin_ff[r][CSR_W-1:COORD_W];
         mat[r][1] = lin_ff[r][COORD_W-1:0];
         mat[r][2] = aff_ff[r][CSR_W-1:COORD_W];
         trans[r]  = aff_ff[r][COORD_W-1:0];
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         lin_in[r] = lin_ff[r];
         aff_in[r] = aff_ff[r];
      end
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_X_LIN: lin_in[0] = csr_wdata;
            CSR_ROW_X_AFF: aff_in[0] = csr_wdata;
            CSR_ROW_Y_LIN: lin_in[1] = csr_wdata;
            CSR_ROW_Y_AFF: aff_in[1] = csr_wdata;
            CSR_ROW_Z_LIN: lin_in[2] = csr_wdata;
            CSR_ROW_Z_AFF: aff_in[2] = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff[0] <= RST_ROW_X_LIN;
         aff_ff[0] <= RST_ROW_X_AFF;
         lin_ff[1] <= RST_ROW_Y_LIN;
         aff_ff[1] <= RST_ROW_Y_AFF;
         lin_ff[2] <= RST_ROW_Z_LIN;
         aff_ff[2] <= RST_ROW_Z_AFF;
      end else begin
         for (int r = 0; r < NUM_AXES; r++) begin
            lin_ff[r] <= lin_in[r];
            aff_ff[r] <= aff_in[r];
         end
      end
   end

   // Floor and saturation are monotonic, so each row's extreme over the eight corners
   // is reached by taking the extreme product for every matrix entry on its own.
   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int c = 0; c < NUM_AXES; c++) begin
            plo_in[r][c] = mat[r][c] * box_lo[c];
            phi_in[r][c] = mat[r][c] * box_hi[c];
            if (plo_ff[r][c] <= phi_ff[r][c]) begin
               tmin_in[r][c] = plo_ff[r][c];
               tmax_in[r][c] = phi_ff[r][c];
            end else begin
               tmin_in[r][c] = phi_ff[r][c];
               tmax_in[r][c] = plo_ff[r][c];
            end
         end
         smin_in[r] = SUM_W'(tmin_ff[r][0]) + SUM_W'(tmin_ff[r][1]) + SUM_W'(tmin_ff[r][2]);
         smax_in[r] = SUM_W'(tmax_ff[r][0]) + SUM_W'(tmax_ff[r][1]) + SUM_W'(tmax_ff[r][2]);
         amin_in[r] = ACC_W'(smin_ff[r] >>> FRAC_BITS) + ACC_W'(trans[r]);
         amax_in[r] = ACC_W'(smax_ff[r] >>> FRAC_BITS) + ACC_W'(trans[r]);
         omin_in[r] = saturate(amin_ff[r]);
         omax_in[r] = saturate(amax_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int c = 0; c < NUM_AXES; c++) begin
            plo_ff[r][c]  <= plo_in[r][c];
            phi_ff[r][c]  <= phi_in[r][c];
            tmin_ff[r][c] <= tmin_in[r][c];
            tmax_ff[r][c] <= tmax_in[r][c];
         end
         smin_ff[r] <= smin_in[r];
         smax_ff[r] <= smax_in[r];
         amin_ff[r] <= amin_in[r];
         amax_ff[r] <= amax_in[r];
         omin_ff[r] <= omin_in[r];
         omax_ff[r] <= omax_in[r];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_min_x = omin_ff[0];
   assign rsp_out_min_y = omin_ff[1];
   assign rsp_out_min_z = omin_ff[2];
   assign rsp_out_max_x = omax_ff[0];
   assign rsp_out_max_y = omax_ff[1];
   assign rsp_out_max_z = omax_ff[2];

endmodule

/* design/aabb_checker.sv */
// Port-level checker for the box transform, with the bind that attaches it.
// Depends on aabb_pkg and on the aabb_affine_transform port list.
`timescale 1ns / 1ps

module aabb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_start,
   input logic               busy,
   input logic               rsp_valid,
   input aabb_pkg::coord_type rsp_out_min_x,
   input aabb_pkg::coord_type rsp_out_min_y,
   input aabb_pkg::coord_type rsp_out_min_z,
   input aabb_pkg::coord_type rsp_out_max_x,
   input aabb_pkg::coord_type rsp_out_max_y,
   input aabb_pkg::coord_type rsp_out_max_z
);
   import aabb_pkg::*;

   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("Transform raised busy.");

   assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy) |-> ##5 rsp_valid)
      else $error("Accepted beat produced no result five cycles later.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start && !busy && !reset, 5))
      else $error("Result beat without a matching accepted beat.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_min_x <= rsp_out_max_x) && (rsp_out_min_y <= rsp_out_max_y)
                    && (rsp_out_min_z <= rsp_out_max_z))
      else $error("Result minimum exceeds result maximum.");

endmodule

bind aabb_affine_transform aabb_checker u_aabb_checker (.*);
